FILE: hw/rtl/asc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg: shared constants for the aliquot sum classifier
// Field widths, result class codes and the default value width.
// ----------------------------------------------------------------------------
package asc_pkg;

    // Default width of the number to classify
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed result field widths
    localparam int CLASS_WIDTH = 2;
    localparam int SUM_WIDTH   = 20;
    localparam int COUNT_WIDTH = 7;

    // Saturation limits of the reported fields
    localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Result class codes
    localparam logic [CLASS_WIDTH-1:0] CLS_DEFICIENT = 2'd0;
    localparam logic [CLASS_WIDTH-1:0] CLS_PERFECT   = 2'd1;
    localparam logic [CLASS_WIDTH-1:0] CLS_ABUNDANT  = 2'd2;

endpackage

FILE: hw/rtl/asc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_div: radix-2 restoring divider
// Produces quotient and remainder one bit per cycle; after the last step,
// done pulses for one cycle with the results valid.
// ----------------------------------------------------------------------------
module asc_div #(
    parameter int VALUE_WIDTH = asc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quot,
    output logic [VALUE_WIDTH-1:0] o_rem
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_quot;
    logic [VALUE_WIDTH:0]   r_rem;
    logic [VALUE_WIDTH-1:0] r_dvs;

    logic [VALUE_WIDTH:0]   trial;
    logic                   fits;

    // One shift-and-subtract step
    assign trial = {r_rem[VALUE_WIDTH-1:0], r_quot[VALUE_WIDTH-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[VALUE_WIDTH-2:0], fits};
            r_rem  <= fits ? (trial - {1'b0, r_dvs}) : trial;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[VALUE_WIDTH-1:0];

endmodule

FILE: hw/rtl/aliquot_sum_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliquot_sum_classifier_core: aliquot sum and perfect number classifier
// Sums the proper divisors of one value by trial division and classifies it.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_value_in and raise start while busy is low; the value is taken at
//   that clock edge and busy rises on the next cycle. Candidates d = 2, 3, ...
//   are tried while d*d <= value; each divisor d adds d and value/d (once if
//   equal) to a running sum that starts at 1.
//   When done, o_valid is high for exactly one cycle with o_number_class,
//   o_aliquot_sum, o_divisor_count and o_is_prime; busy is low in that same
//   cycle, so a new start may be given there.
//   Each candidate costs a compare, one shared serial divider pass, up to
//   two accumulate steps and a step. One item at a time.
//   The result is a one-cycle transfer; the receiver cannot stall it.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_valid; no result is produced for an item in flight.
// ----------------------------------------------------------------------------
module aliquot_sum_classifier_core #(
    parameter int VALUE_WIDTH = asc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [VALUE_WIDTH-1:0]            i_value_in,
    output logic                              o_valid,
    output logic [asc_pkg::CLASS_WIDTH-1:0]   o_number_class,
    output logic [asc_pkg::SUM_WIDTH-1:0]     o_aliquot_sum,
    output logic [asc_pkg::COUNT_WIDTH-1:0]   o_divisor_count,
    output logic                              o_is_prime
);

    // Exact sum, square and extended compare widths
    localparam int SUM_RW  = VALUE_WIDTH + 4;
    localparam int SQ_W    = VALUE_WIDTH + 2;
    localparam int SUM_EXT = (SUM_RW > asc_pkg::SUM_WIDTH) ? SUM_RW : asc_pkg::SUM_WIDTH;
    localparam int CNT_EXT = (VALUE_WIDTH > asc_pkg::COUNT_WIDTH) ?
                             VALUE_WIDTH : asc_pkg::COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ADD_D,
        S_ADD_Q,
        S_STEP,
        S_FINISH
    } t_state;

    t_state                  r_state;
    logic [VALUE_WIDTH-1:0]  r_v;
    logic [VALUE_WIDTH-1:0]  r_d;
    logic [SQ_W-1:0]         r_sq;
    logic [SUM_RW-1:0]       r_sum;
    logic [VALUE_WIDTH-1:0]  r_cnt;
    logic [VALUE_WIDTH-1:0]  r_q;
    logic                    r_valid;
    logic [asc_pkg::CLASS_WIDTH-1:0] r_class;
    logic [asc_pkg::SUM_WIDTH-1:0]   r_sum_out;
    logic [asc_pkg::COUNT_WIDTH-1:0] r_cnt_out;
    logic                    r_prime;

    logic                    more;
    logic                    div_start;
    logic                    div_done;
    logic [VALUE_WIDTH-1:0]  div_quot;
    logic [VALUE_WIDTH-1:0]  div_rem;
    logic [SUM_EXT-1:0]      sum_ext;
    logic [CNT_EXT-1:0]      cnt_ext;

    // Candidate still in range: d*d <= value
    assign more      = (r_sq <= SQ_W'(r_v));
    assign div_start = (r_state == S_CHECK) && more;

    // Saturation views of the sum and count
    assign sum_ext = SUM_EXT'(r_sum);
    assign cnt_ext = CNT_EXT'(r_cnt);

    // Shared trial divider
    asc_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Sequencer with accumulators and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_v     <= i_value_in;
                        r_d     <= VALUE_WIDTH'(2);
                        r_sq    <= SQ_W'(4);
                        r_sum   <= SUM_RW'(1);
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= more ? S_DIV : S_FINISH;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_q     <= div_quot;
                        r_state <= (div_rem == '0) ? S_ADD_D : S_STEP;
                    end
                end
                S_ADD_D: begin
                    r_sum   <= r_sum + SUM_RW'(r_d);
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= (r_q != r_d) ? S_ADD_Q : S_STEP;
                end
                S_ADD_Q: begin
                    r_sum   <= r_sum + SUM_RW'(r_q);
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    // (d+1)^2 = d^2 + 2d + 1
                    r_sq    <= r_sq + SQ_W'({r_d, 1'b1});
                    r_d     <= r_d + 1'b1;
                    r_state <= S_CHECK;
                end
                S_FINISH: begin
                    if (r_sum < SUM_RW'(r_v)) begin
                        r_class <= asc_pkg::CLS_DEFICIENT;
                    end else if (r_sum == SUM_RW'(r_v)) begin
                        r_class <= asc_pkg::CLS_PERFECT;
                    end else begin
                        r_class <= asc_pkg::CLS_ABUNDANT;
                    end
                    r_sum_out <= (sum_ext > SUM_EXT'(asc_pkg::SUM_MAX)) ?
                                 asc_pkg::SUM_MAX : sum_ext[asc_pkg::SUM_WIDTH-1:0];
                    r_cnt_out <= (cnt_ext > CNT_EXT'(asc_pkg::COUNT_MAX)) ?
                                 asc_pkg::COUNT_MAX : cnt_ext[asc_pkg::COUNT_WIDTH-1:0];
                    r_prime   <= (r_cnt == '0);
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_number_class  = r_class;
    assign o_aliquot_sum   = r_sum_out;
    assign o_divisor_count = r_cnt_out;
    assign o_is_prime      = r_prime;

endmodule
